@@ rtl/core/wpm_pkg.sv @@
// wpm_pkg: shared types, op codes and constants of the wildcard pattern matcher
// no dependencies; compiled first
`default_nettype none

package wpm_pkg;

  // default pattern capacity in bytes
  localparam int MAX_PATTERN_DEF = 64;

  // wildcard bytes of the pattern
  localparam logic [7:0] STAR_BYTE = 8'd42;
  localparam logic [7:0] ANY_BYTE  = 8'd63;

  // op codes of the input transaction
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEXT   = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  // command kind after classification
  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_APPEND,
    KIND_TEXT,
    KIND_FINISH
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] symbol;
    logic       sym_star;
    logic       sym_any;
  } cmd_t;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // status of the back end, seen by the top level
  typedef struct packed {
    logic take;
    logic take_finish;
  } back_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/wpm_if.sv @@
// wpm_if: valid/ready channel interfaces for input and result transactions
// no dependencies
`default_nettype none

interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] symbol;

  modport source (output valid, output op, output symbol, input ready);
  modport sink   (input valid, input op, input symbol, output ready);
endinterface

interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic overflow;

  modport source (output valid, output matched, output overflow, input ready);
  modport sink   (input valid, input matched, input overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wildcard_pattern_match_core.sv @@
// wildcard_pattern_match_core: top level of the whole-string wildcard matcher
// depends on wpm_pkg, wpm_if, wpm_front, wpm_queue and wpm_back
`default_nettype none

// channel   dir   payload              meaning
// in_chan   in    op[1:0], symbol[7:0] clear / append pattern byte / text byte / finish
// out_chan  out   matched, overflow    one result transaction per finish
//
// flow: a transaction passes the front register, the command queue and the
//   pattern cell row; the back end retires one command per cycle while no finish
//   waits on a full result register, so the sustained rate is one transaction per
//   cycle; a finish passes the front register, a queue slot and the result register
// the row of cells updates all pattern positions at once through one carry
//   chain of MAX_PATTERN+1 bits, which sets the clock period
// reset: synchronous active low; empties the queue, sets pattern length to
//   zero and the match row to its empty-text value; pattern bytes need none
// stalls: a finish waits at the head of the queue while the result register
//   is still full, and every command behind it waits too; the second queue
//   slot and the front register take two more transactions, then in_chan.ready
//   drops

module wildcard_pattern_match_core
  import wpm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wpm_in_if.sink     in_chan,
  wpm_out_if.source  out_chan
);

  // front to queue
  logic       push_valid;
  logic       push_ready;
  cmd_t       push_cmd;

  // queue to back
  logic       q_valid;
  logic       q_ready;
  cmd_t       q_cmd;

  back_stat_t bstat;

  // accept and classify transactions
  wpm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // decouples the front from stalls of the result channel
  wpm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop_ready  (q_ready)
  );

  // pattern cells, match row and result register
  wpm_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_ready (q_ready),
    .out_chan  (out_chan),
    .stat      (bstat)
  );

  // a new result only follows a finish taken by the back end
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(bstat.take_finish))
    else $error("result raised without a finish command");

  // the back end never takes a command from an empty queue
  a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.take |-> q_valid)
    else $error("back end took a command from an empty queue");

  // no result is pending right after reset
  a_reset_no_result: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_chan.valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

@@ rtl/core/wpm_front.sv @@
// wpm_front: accepts input transactions and classifies them into commands
// depends on wpm_pkg and wpm_if
`default_nettype none

module wpm_front
  import wpm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  wpm_in_if.sink    in_chan,
  output logic      push_valid,
  output cmd_t      push_cmd,
  input  wire logic push_ready
);

  logic hold_valid_r;
  logic hold_valid_nxt;
  cmd_t hold_cmd_r;
  cmd_t cls_cmd;
  logic accept;

  assign in_chan.ready = !hold_valid_r || push_ready;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    cls_cmd          = '0;
    cls_cmd.symbol   = in_chan.symbol;
    cls_cmd.sym_star = (in_chan.symbol == STAR_BYTE);
    cls_cmd.sym_any  = (in_chan.symbol == ANY_BYTE);
    unique case (in_chan.op)
      OP_CLEAR:  cls_cmd.kind = KIND_CLEAR;
      OP_APPEND: cls_cmd.kind = KIND_APPEND;
      OP_TEXT:   cls_cmd.kind = KIND_TEXT;
      OP_FINISH: cls_cmd.kind = KIND_FINISH;
      default:   cls_cmd.kind = KIND_FINISH;
    endcase
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (push_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_cmd_r <= cls_cmd;
    end
  end

  assign push_valid = hold_valid_r;
  assign push_cmd   = hold_cmd_r;

endmodule

`default_nettype wire

@@ rtl/core/wpm_queue.sv @@
// wpm_queue: short command fifo between front and back
// depends on wpm_pkg
`default_nettype none

module wpm_queue
  import wpm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  input  wire cmd_t push_cmd,
  output logic      push_ready,
  output logic      pop_valid,
  output cmd_t      pop_cmd,
  input  wire logic pop_ready
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QPTR_W-1:0] wptr_nxt;
  logic [QPTR_W-1:0] rptr_nxt;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wpm_back.sv @@
// wpm_back: pattern cells, prefix match row and result register
// depends on wpm_pkg and wpm_if
`default_nettype none

module wpm_back
  import wpm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_ready,
  wpm_out_if.source out_chan,
  output back_stat_t stat
);

  localparam int N = MAX_PATTERN;

  logic [7:0] pat_r [N];
  logic [N-1:0] star_r, star_nxt;
  logic [N-1:0] any_r, any_nxt;
  logic [N-1:0] act_r, act_nxt;
  logic [N:0]   endsel_r, endsel_nxt;
  logic [N:0]   row_r, row_nxt;
  logic         ovf_r, ovf_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         matched_r;
  logic         overflow_r;

  logic         take;
  logic         is_clear, is_append, is_text, is_finish;
  logic         restart;
  logic         full;
  logic [N-1:0] wr_vec;
  logic [N-1:0] match_vec;
  logic [N-1:0] gen;
  logic [N-1:0] prop;
  logic         cin;
  logic [N:0]   add_a, add_b, add_sum, carry;

  assign is_clear  = (cmd.kind == KIND_CLEAR);
  assign is_append = (cmd.kind == KIND_APPEND);
  assign is_text   = (cmd.kind == KIND_TEXT);
  assign is_finish = (cmd.kind == KIND_FINISH);

  assign take      = cmd_valid && (!is_finish || !out_valid_r || out_chan.ready);
  assign cmd_ready = take;
  assign restart   = take && !is_text;
  assign full      = endsel_r[N];
  assign wr_vec    = {N{take && is_append}} & endsel_r[N-1:0];

  // each cell compares its own byte against the text byte
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign match_vec[i] = any_r[i] || (pat_r[i] == cmd.symbol);

    always_ff @(posedge clk) begin
      if (wr_vec[i]) begin
        pat_r[i] <= cmd.symbol;
      end
    end
  end

  always_comb begin
    if (is_clear) begin
      star_nxt   = '0;
      any_nxt    = '0;
      act_nxt    = '0;
      endsel_nxt = (N+1)'(1);
    end else begin
      star_nxt   = (star_r & ~wr_vec) | (wr_vec & {N{cmd.sym_star}});
      any_nxt    = (any_r & ~wr_vec) | (wr_vec & {N{cmd.sym_any}});
      act_nxt    = act_r | wr_vec;
      endsel_nxt = (is_append && !full) ? (endsel_r << 1) : endsel_r;
    end
  end

  // row update as a carry chain: a star cell passes its left neighbor on
  always_comb begin
    if (restart) begin
      gen  = '0;
      prop = star_nxt;
      cin  = 1'b1;
    end else begin
      gen  = act_r & ((star_r & row_r[N:1]) |
                      (~star_r & match_vec & row_r[N-1:0]));
      prop = star_r;
      cin  = 1'b0;
    end
    add_a   = {1'b0, gen | prop};
    add_b   = {1'b0, gen};
    add_sum = add_a + add_b + (N+1)'(cin);
    carry   = add_sum ^ add_a ^ add_b;
    row_nxt = {carry[N:1], restart};
  end

  always_comb begin
    ovf_nxt = ovf_r;
    if (is_clear) begin
      ovf_nxt = 1'b0;
    end else if (is_append && full) begin
      ovf_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take && is_finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      star_r      <= '0;
      any_r       <= '0;
      act_r       <= '0;
      endsel_r    <= (N+1)'(1);
      row_r       <= (N+1)'(1);
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take && !is_text && !is_finish) begin
        star_r   <= star_nxt;
        any_r    <= any_nxt;
        act_r    <= act_nxt;
        endsel_r <= endsel_nxt;
        ovf_r    <= ovf_nxt;
      end
      if (take) begin
        row_r <= row_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_finish) begin
      matched_r  <= |(row_r & endsel_r);
      overflow_r <= ovf_r;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.matched  = matched_r;
  assign out_chan.overflow = overflow_r;

  assign stat.take        = take;
  assign stat.take_finish = take && is_finish;

endmodule

`default_nettype wire

@@ verif/tb_wildcard_pattern_match_core.sv @@
// tb_wildcard_pattern_match_core: self-checking bench for the wildcard pattern matcher
// drives pattern/text transactions, predicts match results and compares every result
// depends on wpm_pkg, wpm_if and wildcard_pattern_match_core from the rtl tree

module tb_wildcard_pattern_match_core;
  import wpm_pkg::*;

  // pattern capacity of the instance under test
  localparam int CAPACITY = MAX_PATTERN_DEF;
  // cycles with no transaction on either channel before giving up
  localparam int QUIET_LIMIT = 3000;
  // receiver hold-off long enough to back the whole pipe up to the input
  localparam int HOLDOFF_CYCLES = 64;
  // settle time after the last result
  localparam int DRAIN_CYCLES = 12;

  // one input transaction as queued for the driver
  typedef struct {
    logic [1:0] op;
    logic [7:0] symbol;
  } stim_item_t;

  // one result transaction as predicted
  typedef struct {
    logic matched;
    logic overflow;
  } match_result_t;

  logic clk;
  logic rst_n;

  wpm_in_if  in_if();
  wpm_out_if out_if();

  wildcard_pattern_match_core #(
    .MAX_PATTERN(CAPACITY)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  // transactions waiting for the driver, results waiting for the monitor
  stim_item_t    pending_items[$];
  match_result_t expected_results[$];

  // idling knobs, changed at the falling edge between phases
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // receiver hold-off request: bumped by the sequencer, consumed by the receiver
  int unsigned holdoff_token;
  int unsigned holdoff_seen;
  int unsigned holdoff_left;

  int unsigned mismatch_count;
  int unsigned items_queued;
  int unsigned quiet_cycles;
  stim_item_t  offer_item;
  match_result_t got_result;

  // shadow of the matcher state
  logic [7:0]          shadow_pattern[CAPACITY];
  int unsigned         shadow_length;
  logic [CAPACITY:0]   prefix_ok;
  logic                shadow_overflow;

  // ---------------------------------------------------------------------------
  // predictor
  // prefix_ok[j] means the text seen so far matches pattern bytes 0..j-1
  // ---------------------------------------------------------------------------

  // empty-text row: entry 0 set, then set while every earlier byte is a star
  function automatic void restart_prefix_row();
    int j;
    prefix_ok    = '0;
    prefix_ok[0] = 1'b1;
    for (j = 1; j <= shadow_length; j++) begin
      prefix_ok[j] = prefix_ok[j-1] && (shadow_pattern[j-1] == STAR_BYTE);
    end
  endfunction

  // one text byte: a star extends from the updated left neighbor or keeps its
  // own old bit, anything else consumes the byte from the old left neighbor
  function automatic void consume_text_byte(input logic [7:0] c);
    int   j;
    logic left_old;
    logic here_old;
    logic [7:0] p;
    left_old     = prefix_ok[0];
    prefix_ok[0] = 1'b0;
    for (j = 1; j <= shadow_length; j++) begin
      p        = shadow_pattern[j-1];
      here_old = prefix_ok[j];
      if (p == STAR_BYTE) begin
        prefix_ok[j] = prefix_ok[j-1] || here_old;
      end else begin
        prefix_ok[j] = ((p == c) || (p == ANY_BYTE)) && left_old;
      end
      left_old = here_old;
    end
  endfunction

  // apply one accepted transaction to the shadow state
  function automatic void apply_transaction(input logic [1:0] op, input logic [7:0] sym);
    match_result_t r;
    case (op)
      OP_CLEAR: begin
        shadow_length   = 0;
        shadow_overflow = 1'b0;
        restart_prefix_row();
      end
      OP_APPEND: begin
        // a full pattern drops the byte and flags it; the text restarts anyway
        if (shadow_length < CAPACITY) begin
          shadow_pattern[shadow_length] = sym;
          shadow_length++;
        end else begin
          shadow_overflow = 1'b1;
        end
        restart_prefix_row();
      end
      OP_TEXT: begin
        consume_text_byte(sym);
      end
      default: begin
        r.matched  = prefix_ok[shadow_length];
        r.overflow = shadow_overflow;
        expected_results.push_back(r);
        restart_prefix_row();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // clock and known input values from time zero
  // ---------------------------------------------------------------------------
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.op       = OP_CLEAR;
    in_if.symbol   = 8'h00;
    out_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_token  = 0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // driver: holds a transaction until taken, then offers the next or idles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      in_if.op     <= OP_CLEAR;
      in_if.symbol <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_transaction(in_if.op, in_if.symbol);
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offer_item    = pending_items.pop_front();
          in_if.valid  <= 1'b1;
          in_if.op     <= offer_item.op;
          in_if.symbol <= offer_item.symbol;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      holdoff_seen  = 0;
      holdoff_left  = 0;
    end else begin
      if (holdoff_token != holdoff_seen) begin
        holdoff_seen = holdoff_token;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: matched %0b overflow %0b",
                 $time, out_if.matched, out_if.overflow);
        mismatch_count++;
      end else begin
        got_result = expected_results.pop_front();
        if (out_if.matched !== got_result.matched) begin
          $display("%0t: matched mismatch: expected %0b actual %0b",
                   $time, got_result.matched, out_if.matched);
          mismatch_count++;
        end
        if (out_if.overflow !== got_result.overflow) begin
          $display("%0t: overflow mismatch: expected %0b actual %0b",
                   $time, got_result.overflow, out_if.overflow);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no transaction on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, expected_results.size());
        $display("tb_wildcard_pattern_match_core: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic [1:0] op, input logic [7:0] sym);
    stim_item_t it;
    it.op     = op;
    it.symbol = sym;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // small alphabet so texts actually hit the pattern, with wildcards and stray bytes
  function automatic logic [7:0] pick_pattern_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 2) return STAR_BYTE;
    if (r == 2) return ANY_BYTE;
    if (r == 3) return 8'($urandom_range(255));
    return 8'd97 + 8'($urandom_range(2));
  endfunction

  // text bytes: wildcard bytes in the text are plain bytes
  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'($urandom_range(255));
    if (r == 1) return STAR_BYTE;
    if (r == 2) return ANY_BYTE;
    return 8'd97 + 8'($urandom_range(2));
  endfunction

  // one random sequence: mostly clear, pattern, a few texts each finished;
  // sometimes plain noise; forced_len >= 0 fixes the pattern length
  task automatic add_sequence(input int forced_len);
    int unsigned roll;
    int          plen;
    int          ntext;
    int          k;
    int          j;
    logic [7:0]  pat[$];
    logic [7:0]  txt[$];
    roll = $urandom_range(99);
    if (roll < 15) begin
      // noise: any op, any byte
      repeat ($urandom_range(1, 6)) begin
        queue_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end else begin
      queue_item(OP_CLEAR, 8'($urandom_range(255)));
      if (forced_len >= 0) begin
        plen = forced_len;
      end else if ($urandom_range(24) == 0) begin
        // near or past capacity now and then
        plen = $urandom_range(CAPACITY - 4, CAPACITY + 4);
      end else begin
        plen = $urandom_range(0, 6);
      end
      pat.delete();
      for (k = 0; k < plen; k++) begin
        pat.push_back(pick_pattern_byte());
        queue_item(OP_APPEND, pat[k]);
      end
      ntext = $urandom_range(1, 3);
      for (k = 0; k < ntext; k++) begin
        txt.delete();
        if ($urandom_range(9) < 6) begin
          // text built to fit the pattern, sometimes with one byte spoiled
          for (j = 0; j < pat.size(); j++) begin
            if (pat[j] == STAR_BYTE) begin
              repeat ($urandom_range(0, 2)) txt.push_back(pick_text_byte());
            end else if (pat[j] == ANY_BYTE) begin
              txt.push_back(pick_text_byte());
            end else begin
              txt.push_back(pat[j]);
            end
          end
          if (txt.size() != 0 && $urandom_range(3) == 0) begin
            txt[$urandom_range(txt.size() - 1)] = pick_text_byte();
          end
        end else begin
          repeat ($urandom_range(0, 6)) txt.push_back(pick_text_byte());
        end
        for (j = 0; j < txt.size(); j++) begin
          // broken sequence: a pattern byte lands in the middle of a text
          if (j == txt.size() / 2 && $urandom_range(9) == 0) begin
            queue_item(OP_APPEND, pick_pattern_byte());
          end
          queue_item(OP_TEXT, txt[j]);
        end
        queue_item(OP_FINISH, 8'($urandom_range(255)));
      end
    end
  endtask

  // wait until the driver is empty and every expected result has come
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_if.valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // one random phase with its own idling; the drain at the end is the sender pause
  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned count, input bit with_holdoff);
    int unsigned start_count;
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start_count    = items_queued;
    while (items_queued - start_count < count) begin
      add_sequence(-1);
    end
    if (with_holdoff) begin
      // receiver blocks while the sender keeps offering, so finishes pile up
      holdoff_token++;
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count = 0;
    items_queued   = 0;
    shadow_length  = 0;
    shadow_overflow = 1'b0;
    restart_prefix_row();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, no idling
    @(negedge clk);
    queue_item(OP_FINISH, 8'h00);       // empty pattern, empty text
    queue_item(OP_TEXT,   8'd97);
    queue_item(OP_FINISH, 8'h00);       // empty pattern against a text
    queue_item(OP_APPEND, STAR_BYTE);
    queue_item(OP_FINISH, 8'h00);       // lone star, empty text
    queue_item(OP_TEXT,   STAR_BYTE);   // star in the text is a plain byte
    queue_item(OP_TEXT,   8'hFF);
    queue_item(OP_FINISH, 8'h00);
    queue_item(OP_CLEAR,  8'hFF);
    queue_item(OP_APPEND, ANY_BYTE);
    queue_item(OP_APPEND, 8'hFF);
    queue_item(OP_TEXT,   8'h00);
    queue_item(OP_APPEND, 8'd98);       // append abandons the partial text
    queue_item(OP_TEXT,   8'h00);
    queue_item(OP_TEXT,   8'hFF);
    queue_item(OP_TEXT,   8'd98);
    queue_item(OP_FINISH, 8'h00);
    queue_item(OP_CLEAR,  8'h00);
    queue_item(OP_APPEND, 8'd97);
    queue_item(OP_TEXT,   ANY_BYTE);    // question mark in the text is literal
    queue_item(OP_FINISH, 8'hFF);
    queue_item(OP_TEXT,   8'd97);
    queue_item(OP_FINISH, 8'hFF);
    wait_drained();

    // full pattern plus dropped bytes unless the sequence rolls noise, then the random phases
    add_sequence(CAPACITY + 2);
    wait_drained();
    run_phase(0,  0,  70, 1'b1);
    run_phase(49, 0,  60, 1'b0);
    run_phase(0,  49, 60, 1'b1);
    run_phase(17, 17, 60, 1'b0);
    run_phase(0,  0,  50, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_wildcard_pattern_match_core: done, clean");
    end else begin
      $display("tb_wildcard_pattern_match_core: done, errors");
    end
    $finish;
  end

endmodule
